// ===== hw/rtl/bfl_pkg.sv =====
// Shared types and constants of the page framebuffer line plotter.
package bfl_pkg;

  localparam int PAGE_ROWS = 8;
  localparam int COORD_W   = 10;
  localparam int ERR_W     = 12;

  localparam logic [1:0] KIND_THIN  = 2'd0;
  localparam logic [1:0] KIND_THICK = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [ERR_W-1:0]   err_t;

  typedef struct packed {
    logic load;
    logic advance;
  } walk_ctl_t;

  typedef struct packed {
    logic       at_end;
    logic       onscreen;
    logic [2:0] bit_sel;
  } walk_sts_t;

endpackage

// ===== hw/rtl/bfl_store.sv =====
// Byte-wide frame store with one write port and one registered read port.
module bfl_store #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [7:0]        rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/bfl_walker.sv =====
// Bresenham stepper: holds the cursor and error term and maps the cursor to a store byte.
module bfl_walker
  import bfl_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64,
  parameter int ADDR_W        = 10
) (
  input  logic              clk,
  input  walk_ctl_t         ctl,
  input  coord_t            load_x0,
  input  coord_t            load_y0,
  input  coord_t            load_x1,
  input  coord_t            load_y1,
  output walk_sts_t         sts,
  output logic [ADDR_W-1:0] addr
);

  coord_t cursor_x;
  coord_t cursor_y;
  coord_t target_x;
  coord_t target_y;
  err_t   dist_x;
  err_t   dist_y;
  err_t   step_error;
  logic   dir_x_neg;
  logic   dir_y_neg;

  logic signed [COORD_W:0]  diff_x;
  logic signed [COORD_W:0]  diff_y;
  err_t                     abs_x;
  err_t                     abs_y;
  logic signed [ERR_W:0]    twice;
  logic                     move_x;
  logic                     move_y;
  err_t                     err_next;
  logic [7:0]               col;
  logic [7:0]               row;

  assign diff_x = {load_x1[COORD_W-1], load_x1} - {load_x0[COORD_W-1], load_x0};
  assign diff_y = {load_y1[COORD_W-1], load_y1} - {load_y0[COORD_W-1], load_y0};
  assign abs_x  = diff_x[COORD_W] ? ERR_W'(-diff_x) : ERR_W'(diff_x);
  assign abs_y  = diff_y[COORD_W] ? ERR_W'(-diff_y) : ERR_W'(diff_y);

  assign twice    = {step_error, 1'b0};
  assign move_x   = twice >= $signed({dist_y[ERR_W-1], dist_y});
  assign move_y   = twice <= $signed({dist_x[ERR_W-1], dist_x});
  assign err_next = step_error + (move_x ? dist_y : '0) + (move_y ? dist_x : '0);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cursor_x   <= load_x0;
      cursor_y   <= load_y0;
      target_x   <= load_x1;
      target_y   <= load_y1;
      dist_x     <= abs_x;
      dist_y     <= -abs_y;
      dir_x_neg  <= (diff_x <= 0);
      dir_y_neg  <= (diff_y <= 0);
      step_error <= abs_x - abs_y;
    end else if (ctl.advance) begin
      step_error <= err_next;
      if (move_x) begin
        cursor_x <= dir_x_neg ? cursor_x - coord_t'(1) : cursor_x + coord_t'(1);
      end
      if (move_y) begin
        cursor_y <= dir_y_neg ? cursor_y - coord_t'(1) : cursor_y + coord_t'(1);
      end
    end
  end

  // Coordinates wrap to their low byte before the screen bounds check.
  assign col = cursor_x[7:0];
  assign row = cursor_y[7:0];

  assign sts.at_end   = (cursor_x == target_x) && (cursor_y == target_y);
  assign sts.onscreen = ({1'b0, col} < 9'(SCREEN_WIDTH)) && ({1'b0, row} < 9'(SCREEN_HEIGHT));
  assign sts.bit_sel  = row[2:0];

  assign addr = ADDR_W'(col) + ADDR_W'(ADDR_W'(row[7:3]) * ADDR_W'(SCREEN_WIDTH));

endmodule

// ===== hw/rtl/bresenham_line_into_page_framebuffer_unit.sv =====
// Line plotter into a 1-bit page-organized frame store, top level.
//
// Items arrive on the s_ group: s_tuser carries the command kind (thin line,
// thick line, clear, read byte) and s_tdata the coordinates, color and byte
// index. Every item yields exactly one result item on the m_ group, whose
// m_tdata is the addressed store byte for a read and zero for other kinds.
//
// Each on-screen pixel is a read-modify-write of one store byte: a read
// state, then a write state. A pixel that falls off the screen passes
// the read state without a write, and each pass opens with a load state.
// A thick line runs three passes. A clear sweeps the store at one byte per
// cycle, over SCREEN_WIDTH * ceil(SCREEN_HEIGHT/8) bytes, 1024 by default.
// A read registers the addressed byte and presents it from the finish state.
// One item is processed at a time; the finished result sits in an output
// register, and the next item is taken while it waits. If the receiver
// stalls, the block holds its next result until the register frees up.
// After reset the store is cleared by the same sweep while s_tready stays
// low.
module bresenham_line_into_page_framebuffer_unit
  import bfl_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // start_x[8:0], start_y[17:9], end_x[26:18], end_y[35:27], color[36],
  // byte_index[46:37], zero pad[47]
  input  logic [47:0] s_tdata,
  // kind[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_byte[7:0]
  output logic [7:0]  m_tdata
);

  localparam int PAGE_COUNT  = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int IDX_W       = (ADDR_W > 10) ? ADDR_W : 10;

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_LOAD    = 3'd2;
  localparam logic [2:0] ST_PIX_RD  = 3'd3;
  localparam logic [2:0] ST_PIX_WR  = 3'd4;
  localparam logic [2:0] ST_RD_DATA = 3'd5;
  localparam logic [2:0] ST_FIN     = 3'd6;

  logic [2:0]        state;
  logic [1:0]        cmd_kind;
  logic [1:0]        pass_num;
  logic              major_x;
  logic              color;
  logic              read_ok;
  logic              clr_reply;
  logic [ADDR_W-1:0] clr_addr;
  logic [7:0]        result;
  logic signed [8:0] sx0;
  logic signed [8:0] sy0;
  logic signed [8:0] ex0;
  logic signed [8:0] ey0;

  logic signed [8:0] in_sx;
  logic signed [8:0] in_sy;
  logic signed [8:0] in_ex;
  logic signed [8:0] in_ey;
  logic [9:0]        in_adx;
  logic [9:0]        in_ady;
  logic [IDX_W-1:0]  bidx_wide;

  walk_ctl_t         walk_ctl;
  walk_sts_t         walk_sts;
  logic [ADDR_W-1:0] walk_addr;
  coord_t            ofs;
  coord_t            ld_x0;
  coord_t            ld_y0;
  coord_t            ld_x1;
  coord_t            ld_y1;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]        mem_rdata;
  logic [7:0]        pix_mask;

  logic              accept;
  logic              out_free;
  logic              last_pass;

  assign in_sx     = s_tdata[8:0];
  assign in_sy     = s_tdata[17:9];
  assign in_ex     = s_tdata[26:18];
  assign in_ey     = s_tdata[35:27];
  assign bidx_wide = IDX_W'(s_tdata[46:37]);
  assign in_adx    = (in_ex > in_sx) ? 10'(in_ex - in_sx) : 10'(in_sx - in_ex);
  assign in_ady    = (in_ey > in_sy) ? 10'(in_ey - in_sy) : 10'(in_sy - in_ey);

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign last_pass = (cmd_kind != KIND_THICK) || (pass_num == 2'd2);

  // Thick copies shift the minor axis by minus one pixel first, then by plus one.
  always_comb begin
    case (pass_num)
      2'd1:    ofs = -coord_t'(1);
      2'd2:    ofs = coord_t'(1);
      default: ofs = '0;
    endcase
  end

  assign ld_x0 = coord_t'(sx0) + (major_x ? coord_t'(0) : ofs);
  assign ld_x1 = coord_t'(ex0) + (major_x ? coord_t'(0) : ofs);
  assign ld_y0 = coord_t'(sy0) + (major_x ? ofs : coord_t'(0));
  assign ld_y1 = coord_t'(ey0) + (major_x ? ofs : coord_t'(0));

  assign pix_mask = 8'(1) << walk_sts.bit_sel;

  always_comb begin
    walk_ctl.load    = (state == ST_LOAD);
    walk_ctl.advance = !walk_sts.at_end &&
                       ((state == ST_PIX_WR) || ((state == ST_PIX_RD) && !walk_sts.onscreen));
    mem_we    = (state == ST_CLEAR) || (state == ST_PIX_WR);
    mem_waddr = (state == ST_CLEAR) ? clr_addr : walk_addr;
    mem_wdata = '0;
    if (state == ST_PIX_WR) begin
      mem_wdata = color ? (mem_rdata | pix_mask) : (mem_rdata & ~pix_mask);
    end
    mem_raddr = (state == ST_IDLE) ? bidx_wide[ADDR_W-1:0] : walk_addr;
  end

  bfl_walker #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .ADDR_W        (ADDR_W)
  ) u_walker (
    .clk     (clk),
    .ctl     (walk_ctl),
    .load_x0 (ld_x0),
    .load_y0 (ld_y0),
    .load_x1 (ld_x1),
    .load_y1 (ld_y1),
    .sts     (walk_sts),
    .addr    (walk_addr)
  );

  bfl_store #(
    .DEPTH  (STORE_BYTES),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
      pass_num  <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_FIN)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state) inside
        ST_CLEAR: begin
          if (clr_addr == ADDR_W'(STORE_BYTES - 1)) begin
            clr_addr <= '0;
            result   <= '0;
            state    <= clr_reply ? ST_FIN : ST_IDLE;
          end else begin
            clr_addr <= clr_addr + ADDR_W'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cmd_kind <= s_tuser;
            sx0      <= in_sx;
            sy0      <= in_sy;
            ex0      <= in_ex;
            ey0      <= in_ey;
            color    <= s_tdata[36];
            major_x  <= (in_adx >= in_ady);
            read_ok  <= ({1'b0, bidx_wide} < (IDX_W + 1)'(STORE_BYTES));
            pass_num <= '0;
            unique case (s_tuser) inside
              KIND_THIN, KIND_THICK: state <= ST_LOAD;
              KIND_CLEAR: begin
                clr_reply <= 1'b1;
                clr_addr  <= '0;
                state     <= ST_CLEAR;
              end
              default: state <= ST_RD_DATA;
            endcase
          end
        end
        ST_LOAD: state <= ST_PIX_RD;
        ST_PIX_RD, ST_PIX_WR: begin
          if (state == ST_PIX_RD && walk_sts.onscreen) begin
            state <= ST_PIX_WR;
          end else if (walk_sts.at_end) begin
            if (last_pass) begin
              result <= '0;
              state  <= ST_FIN;
            end else begin
              pass_num <= pass_num + 2'd1;
              state    <= ST_LOAD;
            end
          end else begin
            state <= ST_PIX_RD;
          end
        end
        ST_RD_DATA: begin
          result <= read_ok ? mem_rdata : '0;
          state  <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            m_tvalid  <= 1'b1;
            m_tdata   <= result;
            clr_reply <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // A pixel write always comes in the cycle right after the read of the same byte.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_PIX_WR) |-> ($past(state) == ST_PIX_RD) && ($past(mem_raddr) == mem_waddr))
    else $error("pixel write without matching read");

  // The store is written only by the clear sweep and by pixel updates.
  assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_CLEAR) || (state == ST_PIX_WR))
    else $error("unexpected store write");

  // An on-screen cursor always maps inside the store.
  assert property (@(posedge clk) disable iff (rst)
    ((state == ST_PIX_RD) && walk_sts.onscreen) |->
      ({1'b0, walk_addr} < (ADDR_W + 1)'(STORE_BYTES)))
    else $error("pixel address beyond the store");

  // A result appears only on leaving the finish state.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_FIN))
    else $error("result issued outside finish");

  // A thick line never runs more than three passes.
  assert property (@(posedge clk) disable iff (rst)
    pass_num != 2'd3)
    else $error("pass counter overrun");

endmodule
